### design/sfr_pkg.sv
// sfr_pkg: shared types and constants for the serial frame receiver
// no dependencies
package sfr_pkg;

  localparam logic [7:0] HEADER_RESET        = 8'h7A;
  localparam logic [8:0] BYTES_BEFORE_LENGTH = 9'd3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [8:0] byte_position;
    logic       last_of_frame;
    logic       checksum_good;
  } res_t;

endpackage

### design/serial_frame_receiver_core.sv
// serial_frame_receiver_core: frame parser with output register and skid stage
// depends on sfr_pkg
//
// Usage: one received byte per item on the in_ channel (in_valid / in_stall).
// While idle, a byte equal to the header register opens a frame and produces
// no item. The next two bytes, a length byte L, L payload bytes and one
// checksum byte each come out as an item on the out_ channel with their
// position in the frame. The checksum byte carries last_of_frame, and
// checksum_good reports whether the 8-bit wrapping sum of the earlier
// frame bytes matches it. The header byte is not part of that sum.
// An accepted byte's item is registered in the output register or skid stage.
// Throughput is one byte per cycle while in_stall is low, set by the parse
// logic, which is combinational and sits before the output register.
// When the receiver stalls, one more result is held in a skid stage. In_stall
// rises only while that stage is full, so bytes keep flowing until both output
// stages are full.
// The user must write the header register (cfg_wr_en / cfg_wr_data) only while
// idle; the block does not enforce it. A synchronous reset (rst_n low) returns
// it to idle, empties both output stages and sets the header register to 0x7A.
module serial_frame_receiver_core
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic [8:0] out_byte_position,
  output logic       out_last_of_frame,
  output logic       out_checksum_good
);

  logic [7:0] header_r;
  logic [8:0] rem_r, rem_nxt;
  logic       await_r, await_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [8:0] pos_r, pos_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  res_t       out_r, out_nxt;
  res_t       skid_r, skid_nxt;

  logic       in_acc;
  logic       out_acc;
  logic       res_en;
  res_t       res;
  logic [8:0] rem_adj;
  logic [8:0] rem_dec;
  logic       last;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_acc  = out_valid_r && !out_stall;

  // parse one byte
  always_comb begin
    rem_nxt   = rem_r;
    await_nxt = await_r;
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    res_en    = 1'b0;
    rem_adj   = rem_r;
    if (await_r && rem_r == 9'd1) begin
      rem_adj = rem_r + {1'b0, in_rx_byte} + 9'd1;
    end
    rem_dec = rem_adj - 9'd1;
    last    = (rem_dec == 9'd0);
    res.frame_byte    = in_rx_byte;
    res.byte_position = pos_r;
    res.last_of_frame = last;
    res.checksum_good = last && (sum_r == in_rx_byte);
    if (in_acc) begin
      if (rem_r == 9'd0) begin
        if (in_rx_byte == header_r) begin
          rem_nxt   = BYTES_BEFORE_LENGTH;
          await_nxt = 1'b1;
          sum_nxt   = 8'd0;
          pos_nxt   = 9'd0;
        end
      end else begin
        res_en  = 1'b1;
        rem_nxt = rem_dec;
        if (await_r && rem_r == 9'd1) begin
          await_nxt = 1'b0;
        end
        if (last) begin
          sum_nxt   = 8'd0;
          pos_nxt   = 9'd0;
          await_nxt = 1'b0;
        end else begin
          sum_nxt = sum_r + in_rx_byte;
          pos_nxt = pos_r + 9'd1;
        end
      end
    end
  end

  // output register plus skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_acc || !out_valid_r) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (res_en) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (res_en) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r     <= HEADER_RESET;
      rem_r        <= 9'd0;
      await_r      <= 1'b0;
      sum_r        <= 8'd0;
      pos_r        <= 9'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        header_r <= cfg_wr_data;
      end
      rem_r        <= rem_nxt;
      await_r      <= await_nxt;
      sum_r        <= sum_nxt;
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = out_r.frame_byte;
  assign out_byte_position = out_r.byte_position;
  assign out_last_of_frame = out_r.last_of_frame;
  assign out_checksum_good = out_r.checksum_good;

`ifndef NO_ASSERTIONS
  // skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full with output register empty");

  // a good checksum is only reported on the closing byte
  a_good_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.checksum_good |-> out_r.last_of_frame)
    else $error("checksum_good without last_of_frame");

  // the length phase only exists inside the first three bytes
  a_await_range: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (rem_r != 9'd0) && (rem_r <= BYTES_BEFORE_LENGTH))
    else $error("awaiting length outside the prefix bytes");

  // counter never exceeds 256, the largest payload plus checksum
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 9'd256)
    else $error("bytes remaining out of range");

  // a full skid stage drains into the output once it is taken
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && !skid_valid_r)
    else $error("skid stage did not drain");
`endif

endmodule

### verif/serial_frame_receiver_core_test.sv
`timescale 1ns / 1ps
// serial_frame_receiver_core_test: self-checking bench for the serial frame receiver
// feeds directed and random byte streams, predicts every output item and checks in order
// depends on sfr_pkg and serial_frame_receiver_core
module serial_frame_receiver_core_test;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int TAIL_CYCLES  = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_WAIT     = 17;
  localparam int REPORT_LIMIT = 10;
  localparam int FULL_FRAME   = 1024;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_frame_byte;
  logic [8:0] out_byte_position;
  logic       out_last_of_frame;
  logic       out_checksum_good;

  serial_frame_receiver_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_byte_position(out_byte_position),
    .out_last_of_frame(out_last_of_frame),
    .out_checksum_good(out_checksum_good)
  );

  always #5 clk = ~clk;

  // frame parser state mirrored by the bench
  logic [7:0] hdr_model = HEADER_RESET;
  logic [8:0] bytes_left = '0;
  logic       want_length = 1'b0;
  logic [7:0] frame_sum = '0;
  logic [8:0] next_pos = '0;

  logic [7:0] rx_q[$];
  logic [7:0] frame_body[$];
  res_t       frame_expect_q[$];

  int send_wait_max = 0;
  int recv_wait_max = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  // returns 1 when the byte produces an output item
  function automatic bit frame_step(input logic [7:0] b, output res_t r);
    logic last;
    r = '0;
    if (bytes_left == 0) begin
      if (b == hdr_model) begin
        bytes_left  = BYTES_BEFORE_LENGTH;
        want_length = 1'b1;
        frame_sum   = '0;
        next_pos    = '0;
      end
      return 1'b0;
    end
    if (want_length && bytes_left == 9'd1) begin
      // length byte: payload plus the checksum byte still to come
      bytes_left  = bytes_left + {1'b0, b} + 9'd1;
      want_length = 1'b0;
    end
    bytes_left = bytes_left - 9'd1;
    last = (bytes_left == 0);
    r.frame_byte    = b;
    r.byte_position = next_pos;
    r.last_of_frame = last;
    r.checksum_good = last && (frame_sum == b);
    if (!last) frame_sum = frame_sum + b;
    next_pos = next_pos + 9'd1;
    if (last) begin
      next_pos    = '0;
      frame_sum   = '0;
      want_length = 1'b0;
    end
    return 1'b1;
  endfunction

  // sender
  always @(posedge clk) begin : driver
    res_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid && frame_step(in_rx_byte, r)) frame_expect_q.push_back(r);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (rx_q.size() > 0) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_q.pop_front();
        send_gap   <= $urandom_range(0, send_wait_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // receiver and checker
  always @(posedge clk) begin : monitor
    res_t got, want;
    int   gap_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
    end else begin
      gap_next = (recv_gap > 0) ? recv_gap - 1 : 0;
      if (out_valid && !out_stall) begin
        got = '{out_frame_byte, out_byte_position, out_last_of_frame, out_checksum_good};
        if (frame_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected item: byte %h pos %0d last %b good %b",
                     got.frame_byte, got.byte_position, got.last_of_frame, got.checksum_good);
        end else begin
          want = frame_expect_q.pop_front();
          if (got.frame_byte !== want.frame_byte || got.byte_position !== want.byte_position ||
              got.last_of_frame !== want.last_of_frame ||
              got.checksum_good !== want.checksum_good) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("mismatch: expected byte %h pos %0d last %b good %b,",
                       want.frame_byte, want.byte_position, want.last_of_frame,
                       want.checksum_good, " got byte %h pos %0d last %b good %b",
                       got.frame_byte, got.byte_position,
                       got.last_of_frame, got.checksum_good);
          end
        end
        gap_next = $urandom_range(0, recv_wait_max);
      end
      recv_gap  <= gap_next;
      out_stall <= (gap_next > 0) || (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("serial_frame_receiver_core_test: done, errors");
      $finish;
    end
  end

  task automatic wait_idle();
    while (rx_q.size() > 0 || in_valid || frame_expect_q.size() > 0) @(posedge clk);
    // ignored bytes leave no item behind, so give the pipeline time to drain
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_header(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    hdr_model = v;
  endtask

  // header, then the first keep bytes of frame_body, then the checksum if keep allows
  task automatic emit_frame(input logic [7:0] h, input bit good, input int keep);
    logic [7:0] sum;
    sum = '0;
    rx_q.push_back(h);
    foreach (frame_body[i]) begin
      if (i < keep) rx_q.push_back(frame_body[i]);
      sum = sum + frame_body[i];
    end
    if (keep > frame_body.size())
      rx_q.push_back(good ? sum : sum ^ (8'h01 << $urandom_range(0, 7)));
  endtask

  task automatic fill_body(input int len);
    frame_body.delete();
    repeat (2) frame_body.push_back(8'($urandom));
    frame_body.push_back(len[7:0]);
    repeat (len) frame_body.push_back(8'($urandom));
  endtask

  // mostly well-formed frames, with idle noise and cut-off frames mixed in
  task automatic random_traffic(input int n_items);
    int sent, pick, len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        repeat ($urandom_range(1, 3)) rx_q.push_back(8'($urandom));
        sent += 1;
      end else begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
        fill_body(len);
        emit_frame(hdr_model, $urandom_range(0, 3) != 0,
                   (pick < 22) ? $urandom_range(0, len + 3) : FULL_FRAME);
        sent += len + 5;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset header, extreme bytes, idle noise, header value inside a frame
    send_wait_max = MAX_WAIT;
    recv_wait_max = MAX_WAIT;
    rx_q.push_back(8'h00);
    rx_q.push_back(8'hFF);
    rx_q.push_back(8'h7B);
    frame_body = {8'h00, 8'hFF, 8'h00};
    emit_frame(HEADER_RESET, 1'b1, FULL_FRAME);
    frame_body = {8'h7A, 8'hFF, 8'h02, 8'h7A, 8'hFF};
    emit_frame(HEADER_RESET, 1'b1, FULL_FRAME);
    frame_body = {8'h01, 8'h02, 8'h01, 8'h80};
    emit_frame(HEADER_RESET, 1'b0, FULL_FRAME);
    frame_body = {8'hFF, 8'hFF, 8'h01, 8'hFF};
    emit_frame(HEADER_RESET, 1'b1, FULL_FRAME);
    // frame left open so the next header write lands mid-frame
    frame_body = {8'h11, 8'h22, 8'h03};
    emit_frame(HEADER_RESET, 1'b1, 2);
    wait_idle();

    set_header(8'h00);
    random_traffic(80);
    wait_idle();

    // no idling on either side, plus the longest frame
    set_header(8'hFF);
    send_wait_max = 0;
    recv_wait_max = 0;
    random_traffic(80);
    fill_body(255);
    emit_frame(hdr_model, 1'b1, FULL_FRAME);
    wait_idle();

    // receiver holds off while the sender keeps offering items
    set_header(8'($urandom));
    recv_wait_max = 3;
    random_traffic(80);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    wait_idle();

    set_header(HEADER_RESET);
    send_wait_max = MAX_WAIT;
    recv_wait_max = 0;
    random_traffic(80);
    wait_idle();

    set_header(8'($urandom));
    recv_wait_max = MAX_WAIT;
    random_traffic(80);
    wait_idle();

    if (mismatches == 0) $display("serial_frame_receiver_core_test: done, clean");
    else $display("serial_frame_receiver_core_test: done, errors");
    $finish;
  end

endmodule
